[hw/rtl/ccsj_pkg.sv]
// ccsj_pkg: shared types and constants for the click classifier servo jog unit
// holds payload structs, key phase and class codes, register indexes and reset values
// no dependencies
`default_nettype none

package ccsj_pkg;

	// sizes fixed by the payload layout
	localparam int NUM_CLICK_KEYS = 4;
	localparam int NUM_SERVOS     = 5;
	localparam int ANGLE_W        = 8;
	localparam int COUNT_W        = 4;
	localparam int CFG_INDEX_W    = 3;
	localparam int CFG_DATA_W     = 8;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SAMPLES    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPRESS_SAMPLES = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MOVE_PERIOD     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_JOINT_STEP      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GRIPPER_STEP    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ANGLE       = 3'd5;

	// configuration reset values
	localparam logic [3:0] HOLD_SAMPLES_RST    = 4'd6;
	localparam logic [3:0] REPRESS_SAMPLES_RST = 4'd8;
	localparam logic [7:0] MOVE_PERIOD_RST     = 8'd1;
	localparam logic [3:0] JOINT_STEP_RST      = 4'd1;
	localparam logic [3:0] GRIPPER_STEP_RST    = 4'd2;
	localparam logic [7:0] MAX_ANGLE_RST       = 8'd180;

	// per key classifier phase
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HOLD   = 3'd1,
		PH_WINDOW = 3'd2,
		PH_SINGLE = 3'd3,
		PH_DOUBLE = 3'd4
	} key_phase_t;

	// key class codes as shown in key_classes
	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_SINGLE = 2'd1,
		CLS_DOUBLE = 2'd2
	} key_class_t;

	// one sample tick
	typedef struct packed {
		logic base_up_level;
		logic base_down_level;
		logic shoulder_key;
		logic elbow_key;
		logic wrist_key;
		logic gripper_key;
	} sample_t;

	// one result transaction
	typedef struct packed {
		logic [ANGLE_W-1:0] base_angle;
		logic [ANGLE_W-1:0] shoulder_angle;
		logic [ANGLE_W-1:0] elbow_angle;
		logic [ANGLE_W-1:0] wrist_angle;
		logic [ANGLE_W-1:0] gripper_angle;
		logic [7:0]         key_classes;
	} result_t;

	// servo angle after reset, servo order base, shoulder, elbow, wrist, gripper
	function automatic logic [ANGLE_W-1:0] angle_reset(input int idx);
		logic [ANGLE_W-1:0] r;
		case (idx)
			1:       r = 8'd180;
			2:       r = 8'd90;
			3:       r = 8'd90;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/click_classifier_servo_jog_unit.sv]
// a result transaction is registered and presented in the cycle after its sample is accepted
// throughput: one sample per cycle; the output register can drain while the next sample enters
// a sample is held off only while the output register is full and stalled
// reset: arst_n clears key phases, counts, move divider, output valid, and loads
// the configuration defaults and the servo home angles
// depends on ccsj_pkg
`default_nettype none

module click_classifier_servo_jog_unit (
	input  wire                                       clk,
	input  wire                                       arst_n,
	// sample channel
	input  wire                                       sample_valid,
	output logic                                      sample_stall,
	input  wire  ccsj_pkg::sample_t                   sample,
	// result channel
	output logic                                      result_valid,
	input  wire                                       result_stall,
	output ccsj_pkg::result_t                         result,
	// configuration write port
	input  wire                                       cfg_write_en,
	input  wire  [ccsj_pkg::CFG_INDEX_W-1:0]          cfg_index,
	input  wire  [ccsj_pkg::CFG_DATA_W-1:0]           cfg_data
);

	localparam int NK = ccsj_pkg::NUM_CLICK_KEYS;
	localparam int NS = ccsj_pkg::NUM_SERVOS;
	localparam int AW = ccsj_pkg::ANGLE_W;
	localparam int CW = ccsj_pkg::COUNT_W;

	// configuration registers
	logic [3:0]    hold_samples_q;
	logic [3:0]    repress_samples_q;
	logic [7:0]    move_period_q;
	logic [3:0]    joint_step_q;
	logic [3:0]    gripper_step_q;
	logic [AW-1:0] max_angle_q;

	// per key and servo state
	ccsj_pkg::key_phase_t key_phase_q [NK];
	logic [CW-1:0]        key_count_q [NK];
	logic [NK-1:0]        key_seen_q;
	logic [AW-1:0]        angle_q     [NS];
	logic [7:0]           move_div_q;

	// next state
	ccsj_pkg::key_phase_t key_phase_n [NK];
	logic [CW-1:0]        key_count_n [NK];
	logic [NK-1:0]        key_seen_n;
	ccsj_pkg::key_class_t key_cls     [NK];
	logic [AW-1:0]        angle_n     [NS];
	logic [7:0]           move_div_n;
	logic                 move_tick;
	logic [7:0]           classes_n;
	logic [NK-1:0]        key_level;
	logic                 accept;

	// effective thresholds, zero acts as one
	logic [3:0] hold_eff;
	logic [3:0] repress_eff;
	logic [7:0] period_eff;

	assign hold_eff    = (hold_samples_q == 4'd0) ? 4'd1 : hold_samples_q;
	assign repress_eff = (repress_samples_q == 4'd0) ? 4'd1 : repress_samples_q;
	assign period_eff  = (move_period_q == 8'd0) ? 8'd1 : move_period_q;

	// handshake: hold off input only while a stalled result occupies the output register
	assign sample_stall = result_valid & result_stall;
	assign accept       = sample_valid & ~sample_stall;

	// key levels in key order shoulder, elbow, wrist, gripper
	assign key_level = {sample.gripper_key, sample.wrist_key, sample.elbow_key,
		sample.shoulder_key};

	// clamped upward step, an angle already at or above the clamp stays
	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] a,
		input logic [3:0] amt, input logic [AW-1:0] mx);
		logic [AW:0]   sum;
		logic [AW-1:0] r;
		sum = {1'b0, a} + {{(AW-3){1'b0}}, amt};
		if (a < mx) begin
			r = (sum > {1'b0, mx}) ? mx : sum[AW-1:0];
		end else begin
			r = a;
		end
		return r;
	endfunction

	// downward step that stops at zero
	function automatic logic [AW-1:0] step_down(input logic [AW-1:0] a,
		input logic [3:0] amt);
		logic [AW-1:0] amt_w;
		amt_w = {{(AW-4){1'b0}}, amt};
		return (a > amt_w) ? (a - amt_w) : '0;
	endfunction

	// per key classifier
	always_comb begin
		logic [CW-1:0] cnt_inc;
		for (int k = 0; k < NK; k++) begin
			key_phase_n[k] = key_phase_q[k];
			key_count_n[k] = key_count_q[k];
			key_seen_n[k]  = key_seen_q[k];
			key_cls[k]     = ccsj_pkg::CLS_NONE;
			cnt_inc        = key_count_q[k] + 1'b1;
			case (key_phase_q[k])
				ccsj_pkg::PH_IDLE: begin
					if (key_level[k]) begin
						key_phase_n[k] = ccsj_pkg::PH_HOLD;
						key_count_n[k] = '0;
						key_seen_n[k]  = 1'b0;
					end
				end
				ccsj_pkg::PH_HOLD: begin
					if (key_level[k]) begin
						key_seen_n[k]  = 1'b1;
						key_count_n[k] = cnt_inc;
						if (cnt_inc >= hold_eff) begin
							key_phase_n[k] = ccsj_pkg::PH_SINGLE;
							key_cls[k]     = ccsj_pkg::CLS_SINGLE;
						end
					end else begin
						key_phase_n[k] = ccsj_pkg::PH_WINDOW;
						key_count_n[k] = '0;
					end
				end
				ccsj_pkg::PH_WINDOW: begin
					if (key_level[k]) begin
						key_phase_n[k] = ccsj_pkg::PH_DOUBLE;
						key_cls[k]     = ccsj_pkg::CLS_DOUBLE;
					end else begin
						key_count_n[k] = cnt_inc;
						if (cnt_inc >= repress_eff) begin
							if (key_seen_q[k]) begin
								key_phase_n[k] = ccsj_pkg::PH_SINGLE;
								key_cls[k]     = ccsj_pkg::CLS_SINGLE;
							end else begin
								key_phase_n[k] = ccsj_pkg::PH_IDLE;
							end
						end
					end
				end
				ccsj_pkg::PH_SINGLE: begin
					if (key_level[k]) begin
						key_cls[k] = ccsj_pkg::CLS_SINGLE;
					end else begin
						key_phase_n[k] = ccsj_pkg::PH_IDLE;
					end
				end
				ccsj_pkg::PH_DOUBLE: begin
					if (key_level[k]) begin
						key_cls[k] = ccsj_pkg::CLS_DOUBLE;
					end else begin
						key_phase_n[k] = ccsj_pkg::PH_IDLE;
					end
				end
				default: begin
					key_phase_n[k] = ccsj_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// pack classes, only the first four keys fit the field
	always_comb begin
		classes_n = '0;
		for (int k = 0; k < NK; k++) begin
			if (k < 4) begin
				classes_n[2*k +: 2] = key_cls[k];
			end
		end
	end

	// move divider
	always_comb begin
		logic [8:0] div_sum;
		div_sum    = {1'b0, move_div_q} + 9'd1;
		move_tick  = (div_sum >= {1'b0, period_eff});
		move_div_n = move_tick ? 8'd0 : div_sum[7:0];
	end

	// servo angle update
	always_comb begin
		for (int s = 0; s < NS; s++) begin
			angle_n[s] = angle_q[s];
		end
		if (move_tick) begin
			// base: up step first, then down step
			if (sample.base_up_level) begin
				angle_n[0] = step_up(angle_n[0], joint_step_q, max_angle_q);
			end
			if (sample.base_down_level) begin
				angle_n[0] = step_down(angle_n[0], joint_step_q);
			end
			for (int k = 0; k < NK; k++) begin
				if (k + 1 < NS) begin
					if (k == NK - 1) begin
						// gripper is reversed
						if (key_cls[k] == ccsj_pkg::CLS_SINGLE) begin
							angle_n[k+1] = step_down(angle_q[k+1], gripper_step_q);
						end else if (key_cls[k] == ccsj_pkg::CLS_DOUBLE) begin
							angle_n[k+1] = step_up(angle_q[k+1], gripper_step_q,
								max_angle_q);
						end
					end else begin
						if (key_cls[k] == ccsj_pkg::CLS_SINGLE) begin
							angle_n[k+1] = step_up(angle_q[k+1], joint_step_q,
								max_angle_q);
						end else if (key_cls[k] == ccsj_pkg::CLS_DOUBLE) begin
							angle_n[k+1] = step_down(angle_q[k+1], joint_step_q);
						end
					end
				end
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_samples_q    <= ccsj_pkg::HOLD_SAMPLES_RST;
			repress_samples_q <= ccsj_pkg::REPRESS_SAMPLES_RST;
			move_period_q     <= ccsj_pkg::MOVE_PERIOD_RST;
			joint_step_q      <= ccsj_pkg::JOINT_STEP_RST;
			gripper_step_q    <= ccsj_pkg::GRIPPER_STEP_RST;
			max_angle_q       <= ccsj_pkg::MAX_ANGLE_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				ccsj_pkg::REG_HOLD_SAMPLES:    hold_samples_q    <= cfg_data[3:0];
				ccsj_pkg::REG_REPRESS_SAMPLES: repress_samples_q <= cfg_data[3:0];
				ccsj_pkg::REG_MOVE_PERIOD:     move_period_q     <= cfg_data;
				ccsj_pkg::REG_JOINT_STEP:      joint_step_q      <= cfg_data[3:0];
				ccsj_pkg::REG_GRIPPER_STEP:    gripper_step_q    <= cfg_data[3:0];
				ccsj_pkg::REG_MAX_ANGLE:       max_angle_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// classifier, divider and angle state, advanced once per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NK; k++) begin
				key_phase_q[k] <= ccsj_pkg::PH_IDLE;
				key_count_q[k] <= '0;
			end
			key_seen_q <= '0;
			for (int s = 0; s < NS; s++) begin
				angle_q[s] <= ccsj_pkg::angle_reset(s);
			end
			move_div_q <= '0;
		end else if (accept) begin
			for (int k = 0; k < NK; k++) begin
				key_phase_q[k] <= key_phase_n[k];
				key_count_q[k] <= key_count_n[k];
			end
			key_seen_q <= key_seen_n;
			for (int s = 0; s < NS; s++) begin
				angle_q[s] <= angle_n[s];
			end
			move_div_q <= move_div_n;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (accept) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result.base_angle     <= angle_n[0];
			result.shoulder_angle <= angle_n[1];
			result.elbow_angle    <= angle_n[2];
			result.wrist_angle    <= angle_n[3];
			result.gripper_angle  <= angle_n[4];
			result.key_classes    <= classes_n;
		end
	end

`ifndef SYNTH
	// an accepted sample always leaves a result in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> result_valid)
		else $error("accepted sample produced no result");

	// input is held off only behind a pending result
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("sample stalled with empty output register");

	// shown class agrees with the classifier phase it left behind
	for (genvar g = 0; g < NK && g < 4; g++) begin : g_cls_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			result_valid |->
			((result.key_classes[2*g +: 2] == ccsj_pkg::CLS_SINGLE) ==
			(key_phase_q[g] == ccsj_pkg::PH_SINGLE)))
			else $error("single class and phase disagree");
		assert property (@(posedge clk) disable iff (!arst_n)
			result_valid |->
			((result.key_classes[2*g +: 2] == ccsj_pkg::CLS_DOUBLE) ==
			(key_phase_q[g] == ccsj_pkg::PH_DOUBLE)))
			else $error("double class and phase disagree");
	end
`endif

endmodule

`default_nettype wire
